### sv/stc_pkg.sv
package stc_pkg;

  localparam int unsigned DIV_W = 64;

  localparam logic [19:0] US_PER_S = 20'd1000000;

  // x / 100 and x / 10000 for any 32-bit x: multiply by the rounded-up reciprocal, then shift
  localparam logic [31:0] RCP_100 = 32'd1374389535;
  localparam int unsigned RCP_100_SH = 37;
  localparam logic [31:0] RCP_10000 = 32'd3518437209;
  localparam int unsigned RCP_10000_SH = 45;

  localparam logic [2:0] REG_CLOCK_HZ = 3'd0;
  localparam logic [2:0] REG_COUNTER_BITS = 3'd1;
  localparam logic [2:0] REG_MAX_ON_US = 3'd2;
  localparam logic [2:0] REG_DUTY_Q16 = 3'd3;
  localparam logic [2:0] REG_MAX_RATE = 3'd4;
  localparam logic [2:0] REG_END_MARGIN_US = 3'd5;

  localparam logic CMD_RATE = 1'b0;
  localparam logic CMD_ON_TIME = 1'b1;

  localparam logic [3:0] OP_PSC = 4'd0;
  localparam logic [3:0] OP_ARR = 4'd1;
  localparam logic [3:0] OP_DUTY = 4'd2;
  localparam logic [3:0] OP_FRAME = 4'd3;
  localparam logic [3:0] OP_BASE = 4'd4;
  localparam logic [3:0] OP_DLY100 = 4'd5;
  localparam logic [3:0] OP_TICKS = 4'd6;
  localparam logic [3:0] OP_LED100 = 4'd7;
  localparam logic [3:0] OP_LED = 4'd8;

  typedef struct packed {
    logic       load;
    logic [3:0] op;
    logic       mul_a;
    logic       mul_b;
    logic       start;
    logic       recip;
    logic       commit;
    logic       reject;
  } stc_cmd_t;

  typedef struct packed {
    logic busy;
    logic is_on;
    logic val_zero;
    logic rate_zero;
    logic on_zero;
    logic over_rate;
    logic over_on;
    logic duty_fail;
  } stc_stat_t;

endpackage

### sv/stc_div.sv
module stc_div
  import stc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             busy,
  output logic [DIV_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] q;
  logic [DIV_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0] shifted;
  logic [DIV_W:0] trial;

  assign shifted = {rem, q[DIV_W-1]};
  assign trial = shifted - {1'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      rem <= '0;
      q <= num;
      d <= den;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        q <= {q[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_W-1:0];
        q <= {q[DIV_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### sv/stc_datapath.sv
module stc_datapath
  import stc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stc_cmd_t    ctl,
  output stc_stat_t   stat,
  input  logic        in_cmd,
  input  logic [15:0] in_value,
  input  logic [31:0] clock_hz,
  input  logic [4:0]  counter_bits,
  input  logic [15:0] max_on_us,
  input  logic [16:0] duty_q16,
  input  logic [15:0] max_rate,
  input  logic [15:0] end_margin_us,
  output logic        status,
  output logic [15:0] rate_out,
  output logic [15:0] on_time_out,
  output logic [31:0] prescale_out,
  output logic [31:0] reload_out,
  output logic [31:0] start_count_out,
  output logic [31:0] led_ticks_out
);

  logic        cmd;
  logic [15:0] val;
  logic [31:0] psc;
  logic [31:0] arr;
  logic [31:0] base;
  logic [31:0] q100;
  logic [31:0] prod;
  logic [31:0] ticks;
  logic [31:0] led;
  logic [31:0] frame;
  logic [31:0] st;
  logic [31:0] mul_p;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [DIV_W-1:0] num;
  logic [DIV_W-1:0] den;
  logic [DIV_W-1:0] quo;
  logic        dbusy;
  logic [15:0] new_rate;
  logic [15:0] new_on;
  logic [31:0] delay;
  logic [47:0] duty_lhs;
  logic [47:0] duty_rhs;
  logic [31:0] cur_psc;
  logic [31:0] cur_arr;
  logic [32:0] psc_p1;
  logic        rcp_by100;
  logic [31:0] rcp_x;
  logic [63:0] rcp_p;
  logic [31:0] rcp_q;

  stc_div u_div (
    .clk(clk), .rst(rst), .start(ctl.start), .num(num), .den(den),
    .busy(dbusy), .quo(quo)
  );

  assign new_rate = (cmd == CMD_RATE) ? val : rate_out;
  assign new_on = (cmd == CMD_ON_TIME) ? val : on_time_out;
  assign delay = frame - {16'd0, new_on} - {16'd0, end_margin_us};
  assign cur_psc = (cmd == CMD_RATE) ? psc : prescale_out;
  assign cur_arr = (cmd == CMD_RATE) ? arr : reload_out;
  assign psc_p1 = {1'b0, cur_psc} + 33'd1;
  assign st = (ticks < cur_arr) ? cur_arr - ticks : cur_arr - 32'd1;

  always_comb begin
    mul_x = ctl.mul_a ? base : {16'd0, new_on};
    mul_y = ctl.mul_a ? q100 : {16'd0, new_rate};
    mul_p = mul_x * mul_y;
  end

  assign rcp_by100 = (ctl.op == OP_DLY100) || (ctl.op == OP_LED100);
  assign rcp_x = (ctl.op == OP_DLY100) ? delay :
                 (ctl.op == OP_LED100) ? {16'd0, max_on_us} : prod;
  assign rcp_p = {32'd0, rcp_x} * {32'd0, (rcp_by100 ? RCP_100 : RCP_10000)};
  assign rcp_q = rcp_by100 ? 32'(rcp_p >> RCP_100_SH) : 32'(rcp_p >> RCP_10000_SH);

  always_comb begin
    num = {32'd0, clock_hz};
    den = 64'd1;
    unique case (ctl.op)
      OP_PSC: den = DIV_W'({16'd0, new_rate}) << counter_bits;
      OP_ARR: den = {31'd0, psc_p1} * {48'd0, new_rate};
      OP_FRAME: begin
        num = DIV_W'(US_PER_S);
        den = DIV_W'(new_rate);
      end
      OP_BASE: den = {31'd0, psc_p1};
      default: den = 64'd1;
    endcase
  end

  assign duty_lhs = 48'(US_PER_S) * 48'(duty_q16);
  assign duty_rhs = {prod[31:0], 16'd0};

  assign stat.busy = dbusy;
  assign stat.is_on = cmd;
  assign stat.val_zero = (val == 16'd0);
  assign stat.rate_zero = (new_rate == 16'd0);
  assign stat.on_zero = (new_on == 16'd0);
  assign stat.over_rate = (val > max_rate);
  assign stat.over_on = (new_on > max_on_us);
  assign stat.duty_fail = (duty_lhs < duty_rhs);

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= 1'b0;
      rate_out <= '0;
      on_time_out <= '0;
      prescale_out <= '0;
      reload_out <= '0;
      start_count_out <= '0;
      led_ticks_out <= '0;
    end else begin
      if (ctl.load) begin
        cmd <= in_cmd;
        val <= in_value;
      end
      if (ctl.mul_a || ctl.mul_b) begin
        prod <= mul_p;
      end
      if (!dbusy && !ctl.start) begin
        unique case (ctl.op)
          OP_PSC: psc <= quo[31:0];
          OP_ARR: arr <= quo[31:0];
          OP_FRAME: frame <= quo[31:0];
          OP_BASE: base <= quo[31:0];
          default: ;
        endcase
      end
      if (ctl.recip) begin
        unique case (ctl.op) inside
          OP_DLY100, OP_LED100: q100 <= rcp_q;
          OP_TICKS: ticks <= rcp_q;
          OP_LED: led <= rcp_q;
          default: ;
        endcase
      end
      if (ctl.commit) begin
        status <= 1'b0;
        if (cmd == CMD_RATE) begin
          rate_out <= val;
          prescale_out <= stat.val_zero ? 32'd0 : psc;
          reload_out <= stat.val_zero ? 32'd0 : arr;
        end else begin
          on_time_out <= val;
        end
        if (!stat.rate_zero) begin
          start_count_out <= st;
          led_ticks_out <= led;
        end
      end
      if (ctl.reject) begin
        status <= 1'b1;
      end
    end
  end

endmodule

### sv/stc_ctrl.sv
module stc_ctrl
  import stc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  stc_stat_t stat,
  output stc_cmd_t  ctl
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK = 4'd1;
  localparam logic [3:0] S_DSTART = 4'd2;
  localparam logic [3:0] S_DWAIT = 4'd3;
  localparam logic [3:0] S_DUTY = 4'd4;
  localparam logic [3:0] S_MULT = 4'd5;
  localparam logic [3:0] S_DONE = 4'd6;
  localparam logic [3:0] S_OUT = 4'd7;
  localparam logic [3:0] S_CONST = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] op;
  logic [3:0] op_next;
  logic       ok;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    op_next = op;
    ctl = '0;
    ctl.op = op;
    ok = 1'b0;
    unique case (state)
      S_IDLE: begin
        ctl.load = in_valid;
        if (in_valid) state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.is_on) begin
          if (stat.over_on) begin
            ctl.reject = 1'b1;
            state_next = S_OUT;
          end else begin
            ctl.mul_b = 1'b1;
            op_next = OP_DUTY;
            state_next = S_DUTY;
          end
        end else if (stat.val_zero) begin
          ctl.commit = 1'b1;
          state_next = S_OUT;
        end else if (stat.over_rate) begin
          ctl.reject = 1'b1;
          state_next = S_OUT;
        end else begin
          op_next = OP_PSC;
          state_next = S_DSTART;
        end
      end
      S_DUTY: begin
        ok = stat.rate_zero || stat.on_zero || !stat.duty_fail;
        if (!stat.is_on && stat.over_on && !stat.on_zero) ok = 1'b0;
        if (!ok) begin
          ctl.reject = 1'b1;
          state_next = S_OUT;
        end else if (stat.rate_zero) begin
          ctl.commit = 1'b1;
          state_next = S_OUT;
        end else begin
          op_next = OP_FRAME;
          state_next = S_DSTART;
        end
      end
      S_DSTART: begin
        ctl.start = 1'b1;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat.busy) begin
          state_next = S_DSTART;
          unique case (op)
            OP_PSC: op_next = OP_ARR;
            OP_ARR: begin
              ctl.mul_b = 1'b1;
              op_next = OP_DUTY;
              state_next = S_DUTY;
            end
            OP_FRAME: op_next = OP_BASE;
            OP_BASE: begin
              op_next = OP_DLY100;
              state_next = S_CONST;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_CONST: begin
        ctl.recip = 1'b1;
        unique case (op)
          OP_DLY100: begin
            op_next = OP_TICKS;
            state_next = S_MULT;
          end
          OP_TICKS: op_next = OP_LED100;
          OP_LED100: begin
            op_next = OP_LED;
            state_next = S_MULT;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_MULT: begin
        ctl.mul_a = 1'b1;
        state_next = S_CONST;
      end
      S_DONE: begin
        ctl.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_PSC;
    end else begin
      state <= state_next;
      op <= op_next;
    end
  end

endmodule

### sv/strobe_timer_settings_calc_top.sv
// A range reject or a zero rate is answered without the divider; an on-time change that
// recomputes or a rate change uses up to four passes of the shared radix-2 divider.
// One transaction at a time: a new command is taken only after the last result is accepted.
// Reset (rst, synchronous): held values clear to zero, registers take their defaults.
module strobe_timer_settings_calc_top
  import stc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [15:0] rate_out,
  output logic [15:0] on_time_out,
  output logic [31:0] prescale_out,
  output logic [31:0] reload_out,
  output logic [31:0] start_count_out,
  output logic [31:0] led_ticks_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] clock_hz;
  logic [4:0]  counter_bits;
  logic [15:0] max_on_us;
  logic [16:0] duty_q16;
  logic [15:0] max_rate;
  logic [15:0] end_margin_us;
  stc_cmd_t    ctl;
  stc_stat_t   stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= 32'd168000000;
      counter_bits <= 5'd16;
      max_on_us <= 16'd8000;
      duty_q16 <= 17'd16384;
      max_rate <= 16'd60;
      end_margin_us <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CLOCK_HZ: clock_hz <= cfg_data;
        REG_COUNTER_BITS: counter_bits <= cfg_data[4:0];
        REG_MAX_ON_US: max_on_us <= cfg_data[15:0];
        REG_DUTY_Q16: duty_q16 <= cfg_data[16:0];
        REG_MAX_RATE: max_rate <= cfg_data[15:0];
        REG_END_MARGIN_US: end_margin_us <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  stc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctl(ctl)
  );

  stc_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .stat(stat), .in_cmd(cmd), .in_value(value),
    .clock_hz(clock_hz), .counter_bits(counter_bits), .max_on_us(max_on_us),
    .duty_q16(duty_q16), .max_rate(max_rate), .end_margin_us(end_margin_us),
    .status(status), .rate_out(rate_out), .on_time_out(on_time_out),
    .prescale_out(prescale_out), .reload_out(reload_out),
    .start_count_out(start_count_out), .led_ticks_out(led_ticks_out)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import stc_pkg::*;
;

  typedef struct {
    logic        status;
    logic [15:0] rate;
    logic [15:0] on_time;
    logic [31:0] prescale;
    logic [31:0] reload;
    logic [31:0] start_count;
    logic [31:0] led_ticks;
  } timer_settings_t;

  typedef struct {
    logic        op;
    logic [15:0] val;
    int          exp_status;
  } cmd_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [15:0] value;
  logic        out_valid;
  logic        out_stall;
  logic        status;
  logic [15:0] rate_out;
  logic [15:0] on_time_out;
  logic [31:0] prescale_out;
  logic [31:0] reload_out;
  logic [31:0] start_count_out;
  logic [31:0] led_ticks_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  strobe_timer_settings_calc_top DUT (.*);

  logic [31:0] p_clock_hz;
  logic [4:0]  p_counter_bits;
  logic [15:0] p_max_on_us;
  logic [16:0] p_duty_q16;
  logic [15:0] p_max_rate;
  logic [15:0] p_end_margin_us;
  timer_settings_t held;
  timer_settings_t settings_q[$];
  int send_idle_pct;
  int stall_pct;
  int mismatches;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd80_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic bit duty_too_long(logic [31:0] t, logic [31:0] r);
    return 64'(1000000) * 64'(p_duty_q16) < 64'(t) * 64'(r) * 64'(65536);
  endfunction

  function automatic logic [31:0] us_ticks(logic [31:0] base, logic [31:0] us);
    logic [31:0] prod;
    prod = base * (us / 32'd100);
    return prod / 32'd10000;
  endfunction

  function automatic void recompute(logic [31:0] r, logic [31:0] t, logic [31:0] psc,
                                    logic [31:0] arr, inout logic [31:0] st,
                                    inout logic [31:0] led);
    logic [31:0] delay;
    logic [31:0] base;
    logic [31:0] ticks;
    if (r == 0) return;
    delay = 32'd1000000 / r - t - 32'(p_end_margin_us);
    base = 32'(64'(p_clock_hz) / (64'(psc) + 64'd1));
    ticks = us_ticks(base, delay);
    st = (ticks < arr) ? arr - ticks : arr - 32'd1;
    led = us_ticks(base, 32'(p_max_on_us));
  endfunction

  function automatic timer_settings_t apply_command(logic op, logic [15:0] v);
    logic [31:0] st;
    logic [31:0] led;
    logic [31:0] psc;
    logic [31:0] arr;
    logic [63:0] div;
    held.status = 1'b0;
    if (op == CMD_ON_TIME) begin
      if (v > p_max_on_us || (held.rate != 0 && duty_too_long(v, held.rate))) begin
        held.status = 1'b1;
      end else begin
        held.on_time = v;
        st = held.start_count;
        led = held.led_ticks;
        recompute(held.rate, held.on_time, held.prescale, held.reload, st, led);
        held.start_count = st;
        held.led_ticks = led;
      end
    end else if (v == 0) begin
      held.rate = 0;
      held.prescale = 0;
      held.reload = 0;
    end else if (v > p_max_rate) begin
      held.status = 1'b1;
    end else begin
      div = (64'd1 << p_counter_bits) * 64'(v);
      psc = 32'(64'(p_clock_hz) / div);
      div = (64'(psc) + 64'd1) * 64'(v);
      arr = 32'(64'(p_clock_hz) / div);
      if (held.on_time != 0 &&
          (held.on_time > p_max_on_us || duty_too_long(held.on_time, v))) begin
        held.status = 1'b1;
      end else begin
        st = held.start_count;
        led = held.led_ticks;
        recompute(v, held.on_time, psc, arr, st, led);
        held.rate = v;
        held.prescale = psc;
        held.reload = arr;
        held.start_count = st;
        held.led_ticks = led;
      end
    end
    return held;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    timer_settings_t e;
    if (!rst && out_valid && !out_stall) begin
      if (settings_q.size() == 0) begin
        $error("result with no transaction pending");
        mismatches++;
      end else begin
        e = settings_q.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); mismatches++;
        end
        if (rate_out !== e.rate) begin
          $error("rate_out exp %0d got %0d", e.rate, rate_out); mismatches++;
        end
        if (on_time_out !== e.on_time) begin
          $error("on_time_out exp %0d got %0d", e.on_time, on_time_out); mismatches++;
        end
        if (prescale_out !== e.prescale) begin
          $error("prescale_out exp %0d got %0d", e.prescale, prescale_out); mismatches++;
        end
        if (reload_out !== e.reload) begin
          $error("reload_out exp %0d got %0d", e.reload, reload_out); mismatches++;
        end
        if (start_count_out !== e.start_count) begin
          $error("start_count_out exp %0d got %0d", e.start_count, start_count_out);
          mismatches++;
        end
        if (led_ticks_out !== e.led_ticks) begin
          $error("led_ticks_out exp %0d got %0d", e.led_ticks, led_ticks_out);
          mismatches++;
        end
      end
    end
  end

  task automatic send_command(logic op, logic [15:0] v, int exp_status);
    timer_settings_t e;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    value <= v;
    do @(posedge clk); while (in_stall);
    e = apply_command(op, v);
    if (exp_status >= 0 && e.status !== 1'(exp_status)) begin
      $error("status exp %0d (table) got %0d (predicted)", exp_status, e.status);
      mismatches++;
    end
    if (exp_status >= 0) e.status = 1'(exp_status);
    settings_q.push_back(e);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (settings_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CLOCK_HZ:      p_clock_hz = data;
      REG_COUNTER_BITS:  p_counter_bits = data[4:0];
      REG_MAX_ON_US:     p_max_on_us = data[15:0];
      REG_DUTY_Q16:      p_duty_q16 = data[16:0];
      REG_MAX_RATE:      p_max_rate = data[15:0];
      REG_END_MARGIN_US: p_end_margin_us = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  cmd_row_t directed[20] = '{
    '{CMD_ON_TIME, 16'd0, 0}, '{CMD_ON_TIME, 16'd8000, 0}, '{CMD_ON_TIME, 16'd8001, 1},
    '{CMD_ON_TIME, 16'hFFFF, 1}, '{CMD_RATE, 16'd61, 1}, '{CMD_RATE, 16'hFFFF, 1},
    '{CMD_RATE, 16'd60, 1}, '{CMD_ON_TIME, 16'd4000, 0}, '{CMD_RATE, 16'd60, 0},
    '{CMD_ON_TIME, 16'd4166, 0}, '{CMD_ON_TIME, 16'd4167, 1}, '{CMD_RATE, 16'd0, 0},
    '{CMD_ON_TIME, 16'd0, 0}, '{CMD_RATE, 16'd1, 0}, '{CMD_ON_TIME, 16'd8000, 0},
    '{CMD_RATE, 16'd31, 0}, '{CMD_RATE, 16'd32, 1}, '{CMD_ON_TIME, 16'd123, -1},
    '{CMD_RATE, 16'd59, -1}, '{CMD_RATE, 16'd0, 0}
  };

  logic [31:0] phase_regs[8][6] = '{
    '{32'd168000000, 32'd16, 32'd8000, 32'd16384, 32'd60, 32'd0},
    '{32'hFFFFFFFF, 32'd31, 32'd65535, 32'd65536, 32'd65535, 32'd65535},
    '{32'd1, 32'd1, 32'd0, 32'd0, 32'd1, 32'd0},
    '{32'd100000000, 32'd0, 32'd65535, 32'd131071, 32'd65535, 32'd1000},
    '{32'd0, 32'd8, 32'd1000, 32'd32768, 32'd200, 32'd500},
    '{32'd72000000, 32'd20, 32'd20000, 32'd6553, 32'd1000, 32'd0},
    '{32'd168000000, 32'd16, 32'd8000, 32'd16384, 32'd60, 32'd100},
    '{32'hFFFFFFFF, 32'd1, 32'd30000, 32'd65536, 32'd65535, 32'd0}
  };

  initial begin
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_RATE;
    value = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    p_clock_hz = 32'd168000000;
    p_counter_bits = 5'd16;
    p_max_on_us = 16'd8000;
    p_duty_q16 = 17'd16384;
    p_max_rate = 16'd60;
    p_end_margin_us = 16'd0;
    held = '{1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_command(directed[i].op, directed[i].val, directed[i].exp_status);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 6; r++) write_reg(3'(r), phase_regs[ph][r]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < 180; n++) begin
        if (ph == 2 && n == 90) drain();
        pick = $urandom_range(99);
        if (pick < 40)
          send_command(CMD_RATE, 16'($urandom_range(0, 32'(p_max_rate) + 1)), -1);
        else if (pick < 55)
          send_command(CMD_RATE, 16'($urandom_range(0, 9)), -1);
        else if (pick < 85)
          send_command(CMD_ON_TIME, 16'($urandom_range(0, 32'(p_max_on_us) + 1)), -1);
        else
          send_command(1'($urandom), 16'($urandom), -1);
      end
      drain();
    end

    repeat (600) @(posedge clk);
    if (mismatches == 0 && settings_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
sv/stc_pkg.sv
sv/stc_div.sv
sv/stc_datapath.sv
sv/stc_ctrl.sv
sv/strobe_timer_settings_calc_top.sv
tb/tb_top.sv
